/* rtl/core/assert_macros.svh */
// assertion macros for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define TCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbl failed");

// next-cycle implication, quiet during reset
`define TCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbl failed");

// next-cycle implication, active through reset
`define TCW_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lbl failed");

`endif

/* rtl/core/tcw_pkg.sv */
package tcw_pkg;

    localparam int COLUMNS        = 80;
    localparam int ROWS           = 25;
    localparam int TERMINALS      = 3;
    localparam int CELLS_PER_TERM = ROWS * COLUMNS;
    localparam int CELLS          = TERMINALS * CELLS_PER_TERM;
    localparam int SCROLL_CELLS   = (ROWS - 1) * COLUMNS;

    localparam int AW   = $clog2(CELLS);
    localparam int TW   = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
    localparam int SCW  = $clog2(SCROLL_CELLS);
    localparam int XW   = 7;
    localparam int YW   = 5;
    localparam int IW   = 11;
    localparam int CHW  = 8;
    localparam int ATW  = 4;
    localparam int TIW  = 2;
    localparam int CW   = CHW + ATW;
    localparam int QDEPTH = 2;
    localparam int QPW  = 1;

    localparam logic [ATW-1:0] GREY      = 4'h7;
    localparam logic [CHW-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHW-1:0] CH_NUL    = 8'h00;
    localparam logic [CHW-1:0] CH_LF     = 8'd10;
    localparam logic [CHW-1:0] CH_CR     = 8'd13;
    localparam logic [CW-1:0]  BLANK_CELL = {GREY, CH_SPACE};

    typedef enum logic [1:0] {
        MODE_PUT  = 2'd0,
        MODE_BS   = 2'd1,
        MODE_READ = 2'd2
    } t_mode;

    typedef struct packed {
        t_mode          mode;
        logic [TIW-1:0] term;
        logic [CHW-1:0] ch;
        logic [YW-1:0]  row;
        logic [XW-1:0]  col;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_BLANK,
        ST_RD_WAIT,
        ST_EMIT
    } t_bstate;

    function automatic logic [ATW-1:0] colour_of(input logic [TIW-1:0] t);
        logic [ATW-1:0] c;
        case (t)
            2'd0:    c = 4'hC;
            2'd1:    c = 4'h2;
            2'd2:    c = 4'h3;
            default: c = GREY;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/tcw_front.sv */
module tcw_front
    import tcw_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [1:0]     i_mode,
    input  logic [TIW-1:0] i_terminal,
    input  logic [CHW-1:0] i_character,
    input  logic [YW-1:0]  i_cell_row,
    input  logic [XW-1:0]  i_cell_col,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output t_cmd           o_cmd
);

    t_cmd             r_q [QDEPTH];
    logic [QPW-1:0]   r_wp, r_rp;
    logic [QPW:0]     r_cnt, n_cnt;
    logic             keep, push;
    logic             term_ok;

    assign term_ok = 32'(i_terminal) < TERMINALS;

    // drop transactions that give no result
    always_comb begin
        case (i_mode)
            MODE_PUT:  keep = term_ok && (i_character != CH_NUL);
            MODE_BS:   keep = 1'b1;
            MODE_READ: keep = term_ok;
            default:   keep = 1'b0;
        endcase
    end

    assign push    = i_accept && keep;
    assign o_full  = r_cnt == (QPW+1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{mode: t_mode'(i_mode), term: i_terminal, ch: i_character,
                           row: i_cell_row, col: i_cell_col};
        end
    end

endmodule

/* rtl/core/tcw_back.sv */
module tcw_back
    import tcw_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [TIW-1:0] i_disp,
    input  logic           i_valid,
    input  t_cmd           i_cmd,
    output logic           o_pop,
    output logic           o_clearing,
    output logic           o_strobe,
    output logic [XW-1:0]  o_cursor_x,
    output logic [YW-1:0]  o_cursor_y,
    output logic [IW-1:0]  o_cursor_index,
    output logic           o_cursor_port_update,
    output logic           o_scrolled,
    output logic [CHW-1:0] o_read_char,
    output logic [ATW-1:0] o_read_attr
);

    logic [CW-1:0]  mem [CELLS];
    logic [CW-1:0]  r_rdata;

    t_bstate        r_state, n_state;
    t_cmd           r_cmd;
    logic [TIW-1:0] r_t;
    logic [AW-1:0]  r_addr, n_addr;
    logic [SCW-1:0] r_cnt, n_cnt;
    logic           r_scr, n_scr;
    logic [XW-1:0]  r_col [TERMINALS];
    logic [YW-1:0]  r_row [TERMINALS];

    logic           r_strobe;
    logic [XW-1:0]  r_ox;
    logic [YW-1:0]  r_oy;
    logic [IW-1:0]  r_oi;
    logic           r_opu, r_oscr;
    logic [CHW-1:0] r_och;
    logic [ATW-1:0] r_oat;

    logic           we, re;
    logic [AW-1:0]  waddr, raddr;
    logic [CW-1:0]  wdata;

    logic [TIW-1:0] t;
    logic [TW-1:0]  ti;
    logic           t_ok;
    logic [XW-1:0]  cx;
    logic [YW-1:0]  cy;
    logic [AW-1:0]  base;
    logic           is_nl, at_right, at_bottom, rd_ok;
    logic           cur_we;
    logic [XW-1:0]  cur_x;
    logic [YW-1:0]  cur_y;
    logic           start_scroll, to_emit, to_read;

    // backspace acts on the displayed terminal
    assign t    = (r_cmd.mode == MODE_BS) ? i_disp : r_cmd.term;
    assign ti   = t[TW-1:0];
    assign t_ok = 32'(t) < TERMINALS;
    assign cx   = r_col[ti];
    assign cy   = r_row[ti];
    assign base = AW'(ti) * AW'(CELLS_PER_TERM);
    assign is_nl     = (r_cmd.ch == CH_LF) || (r_cmd.ch == CH_CR);
    assign at_right  = cx == XW'(COLUMNS - 1);
    assign at_bottom = cy == YW'(ROWS - 1);
    assign rd_ok     = (32'(r_cmd.row) < ROWS) && (32'(r_cmd.col) < COLUMNS);

    // execute decisions
    always_comb begin
        cur_we       = 1'b0;
        cur_x        = cx;
        cur_y        = cy;
        start_scroll = 1'b0;
        to_emit      = 1'b0;
        to_read      = 1'b0;
        case (r_cmd.mode)
            MODE_PUT: begin
                if (is_nl || at_right) begin
                    if (at_bottom) begin
                        start_scroll = 1'b1;
                    end else begin
                        cur_we  = 1'b1;
                        cur_x   = '0;
                        cur_y   = cy + 1'b1;
                        to_emit = 1'b1;
                    end
                end else begin
                    cur_we  = 1'b1;
                    cur_x   = cx + 1'b1;
                    to_emit = 1'b1;
                end
            end
            MODE_BS: begin
                if (t_ok) begin
                    cur_we  = 1'b1;
                    to_emit = 1'b1;
                    if (cx == '0) begin
                        if (cy != '0) begin
                            cur_x = XW'(COLUMNS - 1);
                            cur_y = cy - 1'b1;
                        end
                    end else begin
                        cur_x = cx - 1'b1;
                    end
                end
            end
            MODE_READ: begin
                if (rd_ok) begin
                    to_read = 1'b1;
                end else begin
                    to_emit = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:   if (r_addr == AW'(CELLS - 1)) n_state = ST_IDLE;
            ST_IDLE:    if (i_valid) n_state = ST_EXEC;
            ST_EXEC: begin
                if (start_scroll) begin
                    n_state = ST_SCR_RD;
                end else if (to_read) begin
                    n_state = ST_RD_WAIT;
                end else if (to_emit) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCR_RD:  n_state = ST_SCR_WR;
            ST_SCR_WR:  n_state = (r_cnt == SCW'(SCROLL_CELLS - 1)) ? ST_BLANK : ST_SCR_RD;
            ST_BLANK:   if (r_cnt == SCW'(COLUMNS - 1)) n_state = ST_EMIT;
            ST_RD_WAIT: n_state = ST_EMIT;
            ST_EMIT:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        we     = 1'b0;
        re     = 1'b0;
        waddr  = r_addr;
        raddr  = r_addr;
        wdata  = BLANK_CELL;
        n_addr = r_addr;
        n_cnt  = r_cnt;
        n_scr  = r_scr;
        o_pop  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                we     = 1'b1;
                n_addr = r_addr + 1'b1;
            end
            ST_IDLE: begin
                o_pop = i_valid;
                n_scr = 1'b0;
            end
            ST_EXEC: begin
                waddr = base + AW'(cy) * AW'(COLUMNS) + AW'(cx);
                raddr = base + AW'(r_cmd.row) * AW'(COLUMNS) + AW'(r_cmd.col);
                n_addr = base;
                n_cnt  = '0;
                re     = to_read;
                if (r_cmd.mode == MODE_PUT) begin
                    we    = !is_nl;
                    wdata = {colour_of(t), r_cmd.ch};
                end else if (r_cmd.mode == MODE_BS) begin
                    we    = t_ok;
                    waddr = base + AW'(cur_y) * AW'(COLUMNS) + AW'(cur_x);
                end
            end
            ST_SCR_RD: begin
                re    = 1'b1;
                raddr = r_addr + AW'(COLUMNS);
            end
            ST_SCR_WR: begin
                we     = 1'b1;
                wdata  = {colour_of(r_t), r_rdata[CHW-1:0]};
                n_addr = r_addr + 1'b1;
                n_cnt  = (r_cnt == SCW'(SCROLL_CELLS - 1)) ? '0 : r_cnt + 1'b1;
            end
            ST_BLANK: begin
                we     = 1'b1;
                n_addr = r_addr + 1'b1;
                n_cnt  = r_cnt + 1'b1;
                n_scr  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_addr   <= '0;
            r_cnt    <= '0;
            r_scr    <= 1'b0;
            r_strobe <= 1'b0;
            for (int i = 0; i < TERMINALS; i++) begin
                r_col[i] <= '0;
                r_row[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_cnt    <= n_cnt;
            r_scr    <= n_scr;
            r_strobe <= r_state == ST_EMIT;
            if (r_state == ST_EXEC && t_ok) begin
                if (start_scroll) begin
                    r_col[ti] <= '0;
                    r_row[ti] <= YW'(ROWS - 1);
                end else if (cur_we) begin
                    r_col[ti] <= cur_x;
                    r_row[ti] <= cur_y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_cmd <= i_cmd;
        end
        if (r_state == ST_EXEC) begin
            r_t <= t;
        end
        if (r_state == ST_EMIT) begin
            r_ox   <= cx;
            r_oy   <= cy;
            r_oi   <= IW'(cy) * IW'(COLUMNS) + IW'(cx);
            r_opu  <= (r_cmd.mode == MODE_BS) || (t == i_disp);
            r_oscr <= r_scr;
            if (r_cmd.mode == MODE_READ && rd_ok) begin
                r_och <= r_rdata[CHW-1:0];
                r_oat <= r_rdata[CW-1:CHW];
            end else begin
                r_och <= '0;
                r_oat <= '0;
            end
        end
    end

    assign o_clearing           = r_state == ST_CLEAR;
    assign o_strobe             = r_strobe;
    assign o_cursor_x           = r_ox;
    assign o_cursor_y           = r_oy;
    assign o_cursor_index       = r_oi;
    assign o_cursor_port_update = r_opu;
    assign o_scrolled           = r_oscr;
    assign o_read_char          = r_och;
    assign o_read_attr          = r_oat;

endmodule

/* rtl/core/text_console_writer.sv */
// Text console for three 80x25 terminals. start is taken when busy is low; a
// two-entry command queue holds transactions while the executor works, and
// busy rises when it is full. Each result shows for exactly one cycle with
// o_strobe and cannot be held off. A put or backspace passes the queue
// hand-off, the executor step and the registered strobe before its result; a
// read also waits on the registered cell memory read. A scroll copies the
// terminal cell by cell, a read and a write per cell, then blanks the bottom
// row. After reset all 6000 cells of the memory are swept to grey spaces, one
// cell a cycle, with busy high. The user must write the displayed terminal
// through i_cfg_we only while idle; the block itself does not enforce it.
module text_console_writer
    import tcw_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  logic [1:0]     i_mode,
    input  logic [TIW-1:0] i_terminal,
    input  logic [CHW-1:0] i_character,
    input  logic [YW-1:0]  i_cell_row,
    input  logic [XW-1:0]  i_cell_col,
    input  logic           i_cfg_we,
    input  logic [TIW-1:0] i_cfg_wdata,
    output logic           o_strobe,
    output logic [XW-1:0]  o_cursor_x,
    output logic [YW-1:0]  o_cursor_y,
    output logic [IW-1:0]  o_cursor_index,
    output logic           o_cursor_port_update,
    output logic           o_scrolled,
    output logic [CHW-1:0] o_read_char,
    output logic [ATW-1:0] o_read_attr
);

    logic [TIW-1:0] r_disp;
    logic           q_full, q_valid, q_pop, clearing;
    t_cmd           q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp <= '0;
        end else if (i_cfg_we) begin
            r_disp <= i_cfg_wdata;
        end
    end

    assign busy = q_full || clearing;

    tcw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (start && !busy),
        .i_mode      (i_mode),
        .i_terminal  (i_terminal),
        .i_character (i_character),
        .i_cell_row  (i_cell_row),
        .i_cell_col  (i_cell_col),
        .i_pop       (q_pop),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_cmd       (q_cmd)
    );

    tcw_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_disp               (r_disp),
        .i_valid              (q_valid),
        .i_cmd                (q_cmd),
        .o_pop                (q_pop),
        .o_clearing           (clearing),
        .o_strobe             (o_strobe),
        .o_cursor_x           (o_cursor_x),
        .o_cursor_y           (o_cursor_y),
        .o_cursor_index       (o_cursor_index),
        .o_cursor_port_update (o_cursor_port_update),
        .o_scrolled           (o_scrolled),
        .o_read_char          (o_read_char),
        .o_read_attr          (o_read_attr)
    );

endmodule

/* rtl/core/tcw_checker.sv */
`include "assert_macros.svh"

module tcw_checker
    import tcw_pkg::*;
(
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           busy,
    input logic           o_strobe,
    input logic [XW-1:0]  o_cursor_x,
    input logic [YW-1:0]  o_cursor_y,
    input logic [IW-1:0]  o_cursor_index,
    input logic           o_scrolled
);

    `TCW_ASSERT_NXT(a_strobe_gap, i_clk, i_rst_n, o_strobe, !o_strobe)
    `TCW_ASSERT_IMP(a_cursor_range, i_clk, i_rst_n, o_strobe, (32'(o_cursor_x) < COLUMNS) && (32'(o_cursor_y) < ROWS))
    `TCW_ASSERT_IMP(a_cursor_index, i_clk, i_rst_n, o_strobe, 32'(o_cursor_index) == 32'(o_cursor_y) * COLUMNS + 32'(o_cursor_x))
    `TCW_ASSERT_IMP(a_scroll_cursor, i_clk, i_rst_n, o_strobe && o_scrolled, (o_cursor_x == '0) && (32'(o_cursor_y) == ROWS - 1))
    `TCW_ASSERT_NXT_ALWAYS(a_reset_busy, i_clk, !i_rst_n, busy && !o_strobe)

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .o_cursor_x     (o_cursor_x),
    .o_cursor_y     (o_cursor_y),
    .o_cursor_index (o_cursor_index),
    .o_scrolled     (o_scrolled)
);
